// File: design/prdc_pkg.sv
`default_nettype none

package prdc_pkg;

  // Default symmetric limits on the error and on the derivative term.
  localparam logic [30:0] ERROR_LIMIT_DEF = 31'h7FFF_FFFF;
  localparam logic [30:0] DERIV_LIMIT_DEF = 31'h7FFF_FFFF;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  // Operation carried by each input beat.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_KP          = 3'd0,
    CFG_KI_DT       = 3'd1,
    CFG_KD_OVER_DT  = 3'd2,
    CFG_OUT_LIMIT   = 3'd3,
    CFG_INT_LIMIT   = 3'd4,
    CFG_DEAD_BAND   = 3'd5,
    CFG_RAMP_STEP   = 3'd6,
    CFG_RAMP_ENABLE = 3'd7
  } cfg_idx_e;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? MIN32 : MAX32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33:31] != 3'b000) && (v[33:31] != 3'b111)) begin
      r = v[33] ? MIN32 : MAX32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 48-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if ((v[47:31] != 17'h00000) && (v[47:31] != 17'h1FFFF)) begin
      r = v[47] ? MIN32 : MAX32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp a signed value to plus or minus an unsigned 31-bit limit.
  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] r;
    hi = $signed({1'b0, lim});
    lo = -hi;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Gain (unsigned Q15.16) times signed Q16.16, floor shift by 16, saturate.
  function automatic logic signed [31:0] qmul(input logic [30:0] gain,
                                              input logic signed [31:0] x);
    logic signed [63:0] p;
    p = 64'($signed({1'b0, gain})) * 64'(x);
    return sat48(p[63:16]);
  endfunction

endpackage

`default_nettype wire

// File: design/pid_ramp_deadband_controller_core.sv
`default_nettype none

// Channel  | Direction | Handshake                      | Payload
// ---------+-----------+--------------------------------+--------------------------------------
// input    | in        | in_valid_i / in_stall_o        | opcode_i, target_value_i,
//          |           |                                | measured_value_i
// drive    | out       | drive_valid_o / drive_stall_i  | drive_value_o
// config   | in        | cfg_wr_en_i                    | cfg_index_i, cfg_data_i
//
// One beat is accepted per cycle when the drive side keeps up. A sample beat
// passes from the input register through the ramp and error stage, whose
// register feeds the multiply and integral stage into the output register.
// Each history loop closes within its own stage. A clear beat gives no result.
// Reset clears the valid bits, history, integral and configuration registers.
// A drive stall holds the output register and backs up the stages behind it.

module pid_ramp_deadband_controller_core
  import prdc_pkg::*;
#(
  parameter logic [30:0] ERROR_LIMIT = ERROR_LIMIT_DEF,
  parameter logic [30:0] DERIV_LIMIT = DERIV_LIMIT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] target_value_i,
  input  wire logic signed [31:0] measured_value_i,
  // drive channel
  output logic                    drive_valid_o,
  input  wire logic               drive_stall_i,
  output logic signed [31:0]      drive_value_o,
  // configuration
  input  wire logic               cfg_wr_en_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [30:0]        cfg_data_i
);

  // Configuration registers.
  logic [30:0] kp_q, ki_q, kd_q, out_lim_q, int_lim_q, dead_band_q, ramp_step_q;
  logic        ramp_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      out_lim_q   <= '0;
      int_lim_q   <= '0;
      dead_band_q <= '0;
      ramp_step_q <= '0;
      ramp_en_q   <= 1'b0;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KP:          kp_q        <= cfg_data_i;
        CFG_KI_DT:       ki_q        <= cfg_data_i;
        CFG_KD_OVER_DT:  kd_q        <= cfg_data_i;
        CFG_OUT_LIMIT:   out_lim_q   <= cfg_data_i;
        CFG_INT_LIMIT:   int_lim_q   <= cfg_data_i;
        CFG_DEAD_BAND:   dead_band_q <= cfg_data_i;
        CFG_RAMP_STEP:   ramp_step_q <= cfg_data_i;
        CFG_RAMP_ENABLE: ramp_en_q   <= cfg_data_i[0];
      endcase
    end
  end

  // Pipeline valid bits and advance enables.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s2_clear_q;
  logic out_en, s2_en, s1_en;

  assign out_en     = !out_valid_q || !drive_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  // Input register.
  logic               s1_clear_q;
  logic signed [31:0] s1_target_q, s1_measure_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_clear_q   <= (opcode_e'(opcode_i) == OP_CLEAR);
      s1_target_q  <= target_value_i;
      s1_measure_q <= measured_value_i;
    end
  end

  // Stage one: ramp limit, error, dead band test and measurement difference.
  logic signed [31:0] prev_target_q, prev_measure_q;
  logic signed [32:0] ramp_lo_w, ramp_hi_w, err_w, dmeas_w;
  logic signed [31:0] ramp_lo, ramp_hi, target_lim, err_sat, err_clamped, dmeas;
  logic [31:0]        err_mag;
  logic               active;

  always_comb begin
    ramp_lo_w = {prev_target_q[31], prev_target_q} - $signed({2'b00, ramp_step_q});
    ramp_hi_w = {prev_target_q[31], prev_target_q} + $signed({2'b00, ramp_step_q});
    ramp_lo   = sat33(ramp_lo_w);
    ramp_hi   = sat33(ramp_hi_w);

    target_lim = s1_target_q;
    if (ramp_en_q) begin
      if (s1_target_q < ramp_lo) begin
        target_lim = ramp_lo;
      end else if (s1_target_q > ramp_hi) begin
        target_lim = ramp_hi;
      end
    end

    err_w       = {target_lim[31], target_lim} - {s1_measure_q[31], s1_measure_q};
    err_sat     = sat33(err_w);
    err_clamped = clamp_sym(err_sat, ERROR_LIMIT);
    err_mag     = err_clamped[31] ? 32'(-err_clamped) : 32'(err_clamped);
    active      = err_mag > {1'b0, dead_band_q};

    dmeas_w = {prev_measure_q[31], prev_measure_q} - {s1_measure_q[31], s1_measure_q};
    dmeas   = sat33(dmeas_w);
  end

  // Target and measurement history, updated as each beat leaves stage one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_target_q  <= '0;
      prev_measure_q <= '0;
    end else if (s1_valid_q && s2_en) begin
      if (s1_clear_q) begin
        prev_target_q  <= '0;
        prev_measure_q <= '0;
      end else begin
        prev_target_q  <= target_lim;
        prev_measure_q <= s1_measure_q;
      end
    end
  end

  // Stage two register.
  logic signed [31:0] s2_err_q, s2_dmeas_q;
  logic               s2_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_clear_q  <= s1_clear_q;
      s2_err_q    <= err_clamped;
      s2_dmeas_q  <= dmeas;
      s2_active_q <= active;
    end
  end

  // Stage two: three products, integral update and output sum.
  logic signed [31:0] integral_q;
  logic signed [31:0] p_term, i_inc, d_raw, d_term, integ_new, sum_sat, drive_raw, drive;
  logic signed [32:0] integ_w;
  logic signed [33:0] sum_w;

  always_comb begin
    p_term    = qmul(kp_q, s2_err_q);
    i_inc     = qmul(ki_q, s2_err_q);
    d_raw     = qmul(kd_q, s2_dmeas_q);
    d_term    = clamp_sym(d_raw, DERIV_LIMIT);

    integ_w   = {integral_q[31], integral_q} + {i_inc[31], i_inc};
    integ_new = clamp_sym(sat33(integ_w), int_lim_q);

    sum_w     = {{2{p_term[31]}}, p_term} + {{2{integ_new[31]}}, integ_new}
              + {{2{d_term[31]}}, d_term};
    sum_sat   = sat34(sum_w);
    drive_raw = s2_active_q ? sum_sat : 32'sd0;
    drive     = clamp_sym(drive_raw, out_lim_q);
  end

  // Integral accumulator, zeroed by a clear beat, else updated only outside the dead band.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
    end else if (s2_valid_q && out_en) begin
      if (s2_clear_q) begin
        integral_q <= '0;
      end else if (s2_active_q) begin
        integral_q <= integ_new;
      end
    end
  end

  // Output register; a clear beat leaves no result.
  logic signed [31:0] drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q && !s2_clear_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q && !s2_clear_q) begin
      drive_q <= drive;
    end
  end

  assign drive_valid_o = out_valid_q;
  assign drive_value_o = drive_q;

endmodule

`default_nettype wire

// File: tb/sv/pid_ramp_deadband_controller_core_test.sv
`timescale 1ns / 100ps

module pid_ramp_deadband_controller_core_test;
  import prdc_pkg::*;

  localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 9;
  localparam int BEATS_PER_PHASE = 150;

  // One beat of the input channel.
  typedef struct {
    opcode_e            op;
    logic signed [31:0] target;
    logic signed [31:0] measure;
  } ctrl_beat_t;

  // Block ports; every input starts at a known value.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  opcode_e            opcode = OP_SAMPLE;
  logic signed [31:0] target_value = '0;
  logic signed [31:0] measured_value = '0;
  logic               drive_valid;
  logic               drive_stall = 1'b0;
  logic signed [31:0] drive_value;
  logic               cfg_wr_en = 1'b0;
  cfg_idx_e           cfg_index = CFG_KP;
  logic [30:0]        cfg_data = '0;

  // Controller configuration as last written.
  longint gain_p = 0;
  longint gain_i = 0;
  longint gain_d = 0;
  longint drive_limit = 0;
  longint integ_limit = 0;
  longint band_width = 0;
  longint slew_step = 0;
  logic   ramp_on = 1'b0;

  // Controller state mirrored beat by beat.
  logic signed [31:0] integ_acc = '0;
  logic signed [31:0] last_measure = '0;
  logic signed [31:0] last_target = '0;

  ctrl_beat_t         pending_beats[$];
  ctrl_beat_t         cur_beat;
  logic signed [31:0] drive_expect_q[$];

  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_req = 0;
  int          send_mode = 1;
  int          recv_mode = 1;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  logic        beat_slot_free;

  pid_ramp_deadband_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .target_value_i  (target_value),
    .measured_value_i(measured_value),
    .drive_valid_o   (drive_valid),
    .drive_stall_i   (drive_stall),
    .drive_value_o   (drive_value),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint saturate_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    return clamp_range(v, -lim, lim);
  endfunction

  // Q16.16 gain product, floored by the arithmetic shift, then saturated.
  function automatic longint scale_gain(input longint gain, input longint x);
    longint p;
    p = gain * x;
    return saturate_word(p >>> 16);
  endfunction

  // Works out one control sample and queues the drive value it must produce.
  task automatic predict_beat(input ctrl_beat_t b);
    longint tgt, meas, err, mag, p_term, d_term, integ, drv;
    if (b.op == OP_CLEAR) begin
      integ_acc = '0;
      last_measure = '0;
      last_target = '0;
      return;
    end
    tgt = longint'(b.target);
    meas = longint'(b.measure);
    if (ramp_on) begin
      tgt = clamp_range(tgt, saturate_word(longint'(last_target) - slew_step),
                        saturate_word(longint'(last_target) + slew_step));
    end
    err = clamp_sym(saturate_word(tgt - meas), longint'(ERROR_LIMIT_DEF));
    mag = (err < 0) ? -err : err;
    drv = 0;
    // Inside the dead band the integral is left untouched.
    if (mag > band_width) begin
      p_term = scale_gain(gain_p, err);
      integ = saturate_word(longint'(integ_acc) + scale_gain(gain_i, err));
      integ = clamp_sym(integ, integ_limit);
      integ_acc = integ[31:0];
      d_term = scale_gain(gain_d, saturate_word(longint'(last_measure) - meas));
      d_term = clamp_sym(d_term, longint'(DERIV_LIMIT_DEF));
      drv = saturate_word(p_term + integ + d_term);
    end
    drv = clamp_sym(drv, drive_limit);
    last_measure = meas[31:0];
    last_target = tgt[31:0];
    drive_expect_q.push_back(drv[31:0]);
  endtask

  // Idle length: mode 0 never idles, mode 1 idles lightly, mode 2 heavily.
  function automatic int unsigned pick_gap(input int mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < ((mode == 1) ? 70 : 30)) return 0;
    if (r < ((mode == 1) ? 95 : 80)) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [30:0] pick_setting(input int unsigned typical_max);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return GAIN_MAX;
    if (r == 2) return 31'($urandom());
    return 31'($urandom_range(0, typical_max));
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return MAX32;
      1: return MIN32;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  task automatic queue_beat(input opcode_e op, input logic signed [31:0] tgt,
                            input logic signed [31:0] meas);
    pending_beats.push_back('{op, tgt, meas});
  endtask

  // Waits until every beat is in and every drive value is out, then lets the
  // pipeline empty of clear beats, which give no drive value. The check runs
  // on the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid || drive_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic load_config(input logic [30:0] kp, input logic [30:0] ki,
                             input logic [30:0] kd, input logic [30:0] out_lim,
                             input logic [30:0] int_lim, input logic [30:0] band,
                             input logic [30:0] step, input logic en);
    wait_idle();
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI_DT, ki);
    write_reg(CFG_KD_OVER_DT, kd);
    write_reg(CFG_OUT_LIMIT, out_lim);
    write_reg(CFG_INT_LIMIT, int_lim);
    write_reg(CFG_DEAD_BAND, band);
    write_reg(CFG_RAMP_STEP, step);
    write_reg(CFG_RAMP_ENABLE, {30'd0, en});
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    gain_p = longint'(kp);
    gain_i = longint'(ki);
    gain_d = longint'(kd);
    drive_limit = longint'(out_lim);
    integ_limit = longint'(int_lim);
    band_width = longint'(band);
    slew_step = longint'(step);
    ramp_on = en;
  endtask

  // Input driver: predicts each accepted beat and offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      beat_slot_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        predict_beat(cur_beat);
      end
      if (beat_slot_free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          opcode <= cur_beat.op;
          target_value <= cur_beat.target;
          measured_value <= cur_beat.measure;
          send_gap = pick_gap(send_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Drive monitor: checks each accepted drive beat and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drive_valid && !drive_stall) begin
        if (drive_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected drive beat, actual %0d", $time, drive_value);
        end else if (drive_value !== drive_expect_q[0]) begin
          fail_count++;
          $display("%0t: drive_value mismatch, expected %0d actual %0d",
                   $time, drive_expect_q[0], drive_value);
          void'(drive_expect_q.pop_front());
        end else begin
          void'(drive_expect_q.pop_front());
        end
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        drive_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(recv_mode);
        drive_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (drive_valid && !drive_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("** pid_ramp_deadband_controller_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic signed [31:0] walk_tgt;
    logic signed [31:0] walk_meas;
    int                 d;
    int unsigned        sel;
    walk_tgt = '0;
    walk_meas = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset configuration every output is clamped to zero.
    queue_beat(OP_SAMPLE, 32'sh1234_5678, -32'sd5);
    queue_beat(OP_CLEAR, MAX32, MIN32);

    // Unit-ish gains, no limits: saturated differences and rounding.
    load_config(31'h1_0000, 31'h8000, 31'h4000, GAIN_MAX, GAIN_MAX, '0, '0, 1'b0);
    queue_beat(OP_SAMPLE, MAX32, MIN32);
    queue_beat(OP_SAMPLE, MIN32, MAX32);
    queue_beat(OP_SAMPLE, MIN32, 32'sd0);
    queue_beat(OP_SAMPLE, 32'sd0, 32'sd0);
    queue_beat(OP_SAMPLE, 32'sd1, 32'sd0);
    queue_beat(OP_SAMPLE, -32'sd1, 32'sd0);
    queue_beat(OP_SAMPLE, 32'sd0, MIN32);
    queue_beat(OP_SAMPLE, 32'sd0, MAX32);
    queue_beat(OP_CLEAR, 32'sd7, 32'sd9);
    queue_beat(OP_SAMPLE, 32'sh1_0000, 32'sd0);

    // Full-scale gains saturate the products; ramp bounds saturate too.
    load_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, 31'h12_3456, 31'h5_0000, 31'h2_0000,
                GAIN_MAX, 1'b1);
    queue_beat(OP_SAMPLE, MAX32, 32'sd0);
    queue_beat(OP_SAMPLE, MAX32, 32'sd0);
    queue_beat(OP_SAMPLE, MIN32, 32'sd0);
    queue_beat(OP_SAMPLE, 32'sh2_0000, 32'sd0);
    queue_beat(OP_SAMPLE, 32'sh2_0001, 32'sd0);
    queue_beat(OP_SAMPLE, -32'sh2_0001, 32'sd5);
    queue_beat(OP_CLEAR, -32'sd1, -32'sd1);

    // Small ramp step limits target slew in both directions.
    load_config(31'h1_0000, '0, '0, GAIN_MAX, '0, '0, 31'h8000, 1'b1);
    queue_beat(OP_SAMPLE, 32'sh10_0000, 32'sd0);
    queue_beat(OP_SAMPLE, -32'sh10_0000, 32'sd0);
    queue_beat(OP_SAMPLE, MIN32, MIN32);
    queue_beat(OP_SAMPLE, 32'sh4000, 32'sh4000);

    // Random phases: a loop-like walk of target and measurement, with jumps,
    // full-range values and occasional clears.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_config(pick_setting(32'h3_0000), pick_setting(32'h1_0000),
                  pick_setting(32'h3_0000), pick_setting(32'h400_0000),
                  pick_setting(32'h200_0000), pick_setting(32'h8000),
                  pick_setting(32'h4_0000), 1'($urandom_range(0, 1)));
      send_mode = phase % 3;
      recv_mode = (phase + 1) % 3;
      // One phase holds the drive side off so the pipeline backs up.
      if (phase == 3) begin
        send_mode = 0;
        hold_req = HOLD_CYCLES;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          queue_beat(OP_CLEAR, $urandom(), $urandom());
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 8) begin
            walk_tgt = pick_extreme();
          end else if (sel < 25) begin
            walk_tgt = $urandom();
          end else begin
            d = int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
            walk_tgt = walk_tgt + d;
          end
          sel = $urandom_range(0, 99);
          if (sel < 8) begin
            walk_meas = pick_extreme();
          end else if (sel < 20) begin
            walk_meas = $urandom();
          end else begin
            d = int'($urandom_range(0, 32'h1_0000)) - 32'sh8000;
            walk_meas = walk_meas + ((walk_tgt - walk_meas) >>> 2) + d;
          end
          queue_beat(OP_SAMPLE, walk_tgt, walk_meas);
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("** pid_ramp_deadband_controller_core: PASSED **");
    end else begin
      $display("** pid_ramp_deadband_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
design/prdc_pkg.sv
design/pid_ramp_deadband_controller_core.sv
tb/sv/pid_ramp_deadband_controller_core_test.sv
